// ===== design/bracket_balance_checker_core_assert.svh =====
// Assertion macros for the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bracket checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bracket checker: next-cycle check failed");

`endif

// ===== design/bbc_pkg.sv =====
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

  localparam int unsigned BBC_STACK_DEPTH = 64;
  localparam int unsigned BBC_POS_BITS    = 16;
  localparam int unsigned BBC_OUT_W       = 16;
  localparam int unsigned BBC_QUEUE_DEPTH = 2;

  localparam logic [15:0] CH_LF     = 16'd10;
  localparam logic [15:0] CH_PAR_O  = 16'h0028;
  localparam logic [15:0] CH_PAR_C  = 16'h0029;
  localparam logic [15:0] CH_SQR_O  = 16'h005B;
  localparam logic [15:0] CH_SQR_C  = 16'h005D;
  localparam logic [15:0] CH_CUR_O  = 16'h007B;
  localparam logic [15:0] CH_CUR_C  = 16'h007D;

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_OPENED = 3'd1,
    ST_WRONG      = 3'd2,
    ST_NOT_CLOSED = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_NL    = 3'd1,
    CL_OPEN  = 3'd2,
    CL_CLOSE = 3'd3,
    CL_OTHER = 3'd4
  } class_t;

  typedef struct packed {
    class_t cls;
    kind_t  kind;
    logic   eot;
  } item_t;

endpackage

// ===== design/bbc_if.sv =====
// Text and result channel interfaces of the bracket balance checker.
interface bbc_text_if;
  logic        valid;
  logic        ready;
  logic [15:0] ch;
  logic        ch_valid;
  logic        end_of_text;

  modport source (output valid, output ch, output ch_valid, output end_of_text, input ready);
  modport sink   (input valid, input ch, input ch_valid, input end_of_text, output ready);
endinterface

interface bbc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] err_line;
  logic [15:0] err_col;

  modport source  (output valid, output status, output err_line, output err_col, input ready);
  modport sink    (input valid, input status, input err_line, input err_col, output ready);
endinterface

// ===== design/bbc_front.sv =====
// Front end: accept text beats and classify each character.
module bbc_front (
  bbc_text_if.sink      text,
  output logic          q_valid,
  input  logic          q_ready,
  output bbc_pkg::item_t q_item
);
  import bbc_pkg::*;

  logic keep;

  assign keep       = text.ch_valid || text.end_of_text;
  assign text.ready = q_ready;
  assign q_valid    = text.valid && keep;

  always_comb begin
    q_item.eot  = text.end_of_text;
    q_item.kind = KIND_PAREN;
    q_item.cls  = CL_OTHER;
    if (!text.ch_valid) begin
      q_item.cls = CL_NONE;
    end else begin
      unique case (text.ch)
        CH_LF:    q_item.cls = CL_NL;
        CH_PAR_O: begin q_item.cls = CL_OPEN;  q_item.kind = KIND_PAREN;  end
        CH_SQR_O: begin q_item.cls = CL_OPEN;  q_item.kind = KIND_SQUARE; end
        CH_CUR_O: begin q_item.cls = CL_OPEN;  q_item.kind = KIND_CURLY;  end
        CH_PAR_C: begin q_item.cls = CL_CLOSE; q_item.kind = KIND_PAREN;  end
        CH_SQR_C: begin q_item.cls = CL_CLOSE; q_item.kind = KIND_SQUARE; end
        CH_CUR_C: begin q_item.cls = CL_CLOSE; q_item.kind = KIND_CURLY;  end
        default:  q_item.cls = CL_OTHER;
      endcase
    end
  end

endmodule

// ===== design/bbc_queue.sv =====
// Short queue of classified items between front and back.
module bbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bbc_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output bbc_pkg::item_t rd_item
);
  import bbc_pkg::*;

  localparam int unsigned PW = $clog2(BBC_QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(BBC_QUEUE_DEPTH + 1);

  item_t          slots [BBC_QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  fill;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = (fill != NW'(BBC_QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + NW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// ===== design/bbc_back.sv =====
// Back end: bracket stack, position tracking, error latch and result register.
module bbc_back #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH,
  parameter int unsigned POS_BITS    = bbc_pkg::BBC_POS_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  bbc_pkg::item_t item,
  bbc_result_if.source   result
);
  import bbc_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  typedef struct packed {
    kind_t               kind;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] col;
  } entry_t;

  entry_t              mem [STACK_DEPTH];
  entry_t              top, top_next;
  entry_t              below;
  entry_t              bottom, bottom_next;
  entry_t              new_entry;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rd_idx;
  logic [POS_BITS-1:0] line_now, line_now_next;
  logic [POS_BITS-1:0] col_now, col_now_next;
  status_t             err_code, err_code_next;
  logic [POS_BITS-1:0] err_line, err_line_next;
  logic [POS_BITS-1:0] err_col, err_col_next;
  logic                go;
  logic                push;
  logic                adv_col;
  status_t             fin_code;
  logic [POS_BITS-1:0] fin_line;
  logic [POS_BITS-1:0] fin_col;
  logic [POS_BITS+BBC_OUT_W-1:0] ext_line;
  logic [POS_BITS+BBC_OUT_W-1:0] ext_col;
  logic                res_valid;
  status_t             res_status;
  logic [BBC_OUT_W-1:0] res_line;
  logic [BBC_OUT_W-1:0] res_col;

  assign item_ready = !item.eot || !res_valid || result.ready;
  assign go         = item_valid && item_ready;
  assign new_entry  = '{kind: item.kind, line: line_now, col: col_now};
  assign rd_idx     = count_next - CW'(2);

  always_comb begin
    top_next      = top;
    bottom_next   = bottom;
    count_next    = count;
    line_now_next = line_now;
    col_now_next  = col_now;
    err_code_next = err_code;
    err_line_next = err_line;
    err_col_next  = err_col;
    push          = 1'b0;
    adv_col       = 1'b0;

    if (go && err_code == ST_OK) begin
      unique case (item.cls)
        CL_NL: begin
          if (line_now != POS_MAX) begin
            line_now_next = line_now + POS_ONE;
          end
          col_now_next = POS_ONE;
        end
        CL_OPEN: begin
          if (count == CW'(STACK_DEPTH)) begin
            err_code_next = ST_OVERFLOW;
            err_line_next = line_now;
            err_col_next  = col_now;
          end else begin
            push        = 1'b1;
            top_next    = new_entry;
            count_next  = count + CW'(1);
            adv_col     = 1'b1;
            if (count == '0) begin
              bottom_next = new_entry;
            end
          end
        end
        CL_CLOSE: begin
          if (count == '0) begin
            err_code_next = ST_NOT_OPENED;
            err_line_next = line_now;
            err_col_next  = col_now;
          end else if (top.kind != item.kind) begin
            err_code_next = ST_WRONG;
            err_line_next = line_now;
            err_col_next  = col_now;
          end else begin
            top_next   = below;
            count_next = count - CW'(1);
            adv_col    = 1'b1;
          end
        end
        CL_OTHER: adv_col = 1'b1;
        CL_NONE:  adv_col = 1'b0;
        default:  adv_col = 1'b0;
      endcase
    end

    if (adv_col && col_now != POS_MAX) begin
      col_now_next = col_now + POS_ONE;
    end

    fin_code = err_code_next;
    fin_line = err_line_next;
    fin_col  = err_col_next;
    if (err_code_next == ST_OK && count_next != '0) begin
      fin_code = ST_NOT_CLOSED;
      fin_line = bottom_next.line;
      fin_col  = bottom_next.col;
    end
    ext_line = {{BBC_OUT_W{1'b0}}, fin_line};
    ext_col  = {{BBC_OUT_W{1'b0}}, fin_col};

    if (go && item.eot) begin
      count_next    = '0;
      line_now_next = POS_ONE;
      col_now_next  = POS_ONE;
      err_code_next = ST_OK;
      err_line_next = '0;
      err_col_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[count[AW-1:0]] <= new_entry;
    end
    if (count_next >= CW'(2)) begin
      below <= mem[rd_idx[AW-1:0]];
    end
    top    <= top_next;
    bottom <= bottom_next;
    if (go && item.eot) begin
      res_status <= fin_code;
      res_line   <= ext_line[BBC_OUT_W-1:0];
      res_col    <= ext_col[BBC_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      line_now  <= POS_ONE;
      col_now   <= POS_ONE;
      err_code  <= ST_OK;
      err_line  <= '0;
      err_col   <= '0;
      res_valid <= 1'b0;
    end else begin
      count    <= count_next;
      line_now <= line_now_next;
      col_now  <= col_now_next;
      err_code <= err_code_next;
      err_line <= err_line_next;
      err_col  <= err_col_next;
      if (go && item.eot) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid    = res_valid;
  assign result.status   = res_status;
  assign result.err_line = res_line;
  assign result.err_col  = res_col;

endmodule

// ===== design/bracket_balance_checker_core.sv =====
// Bracket balance checker: takes one text beat per cycle while not stalled, at most one result
// per text. Each text beat carries one 16-bit character; a beat with ch_valid low only marks
// the end of the text if end_of_text is high, else it is dropped. The front classifies the
// character in the cycle it is accepted and writes it into a two-entry queue; the back updates
// line, column and a bracket stack of STACK_DEPTH entries per character. The rate is set by
// the back stage's push or pop: the top entry sits in a register and the entry below it is
// prefetched from the stack memory's one read port in the cycle before it is needed. The
// result is registered when the back stage takes the end-of-text item; only an end-of-text
// beat waits while an earlier result is untaken. After each result the block is ready for
// the next text with no clearing pass. Status 1 to 4 report the first error (closer with
// nothing open, wrong closer, bracket left open at its oldest opener, stack overflow);
// positions are 1-based and saturate at 2^POS_BITS - 1.
module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH,
  parameter int unsigned POS_BITS    = bbc_pkg::BBC_POS_BITS
) (
  input  logic         clk,
  input  logic         rst,
  bbc_text_if.sink     text,
  bbc_result_if.source result
);
  import bbc_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  bbc_front u_front (
    .text    (text),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_item  (f_item)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .result     (result)
  );

endmodule

// ===== design/bbc_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`include "bracket_balance_checker_core_assert.svh"

module bbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  status,
  input logic [15:0] err_line,
  input logic [15:0] err_col
);
  import bbc_pkg::*;

  `BBC_ASSERT_NXT(a_hold_valid, clk, rst, valid && !ready, valid)
  `BBC_ASSERT_NXT(a_hold_beat, clk, rst, valid && !ready, $stable(status) && $stable(err_line) && $stable(err_col))
  `BBC_ASSERT_IMP(a_status_range, clk, rst, valid, status <= ST_OVERFLOW)
  `BBC_ASSERT_IMP(a_ok_no_pos, clk, rst, valid && status == ST_OK, err_line == '0 && err_col == '0)

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
  .clk      (clk),
  .rst      (rst),
  .valid    (result.valid),
  .ready    (result.ready),
  .status   (result.status),
  .err_line (result.err_line),
  .err_col  (result.err_col)
);
